### hdl/amcd_pkg.sv
package amcd_pkg;

  localparam int unsigned WordW = 64;

  localparam logic [3:0] DEC_BASE = 4'd10;
  localparam logic [3:0] MAX_EXP  = 4'd9;

  // Reciprocal constants for the 16-bit-per-cycle divide by a small constant
  localparam int unsigned RecipShift = 24;
  localparam int unsigned RecipW     = 21;
  localparam logic [RecipW-1:0] RECIP_10 = RecipW'((2 ** RecipShift) / 10);
  localparam logic [RecipW-1:0] RECIP_9  = RecipW'((2 ** RecipShift) / 9);

  localparam int unsigned ChunkW  = 16;
  localparam int unsigned NChunks = WordW / ChunkW;

  typedef logic [WordW-1:0] word_t;

endpackage

### hdl/amount_compress_decompress_unit.sv
// Amount compressor / decompressor for transaction output values.
//
// Input channel: in_valid / in_stall with kind (0 compress, 1 decompress) and
// value_in. Output channel: out_valid / out_stall with value_out, one result
// item per input item, wrapped modulo 2^64.
//
// A single shared divide-by-constant unit (10 or 9) handles 16 bits of the
// dividend per cycle. A shared times-ten adder does the scaling back. Steps
// from accept to the final state, which loads the output register:
//   Zero input:   straight to the final state.
//   Compress:     one divide per trailing zero plus one (at most 9 divides),
//                 then 2 packing steps, or 1 scaling step after nine zeros.
//   Decompress:   a divide by ten and a divide by nine, 1 forming step, 1
//                 times-ten step per exponent step (at most 8); exponent 9
//                 skips the second divide and the forming step.
// in_stall is high from accept until the result moves to the output register;
// the next item can be accepted in the cycle after, even while that result waits.
// A stalled result holds value_out and a finished computation waits in its
// last state. Reset (rst, synchronous) returns to idle and drops any result.
module amount_compress_decompress_unit
  import amcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [63:0] value_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] value_out
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CDIV   = 3'd1;
  localparam logic [2:0] S_CPACK  = 3'd2;
  localparam logic [2:0] S_DDIV10 = 3'd3;
  localparam logic [2:0] S_DDIV9  = 3'd4;
  localparam logic [2:0] S_DFORM  = 3'd5;
  localparam logic [2:0] S_DMUL   = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0] state, state_next;
  word_t      acc, acc_next;
  logic [3:0] exp_cnt, exp_cnt_next;
  logic [3:0] digit, digit_next;
  logic [3:0] rem, rem_next;
  logic [1:0] div_cnt, div_cnt_next;
  logic       pack_hi, pack_hi_next;
  logic       out_load;

  // Shared divide unit: one 16-bit chunk of acc per cycle, MSB first
  logic [3:0]        dv_d;
  logic [RecipW-1:0] dv_m;
  logic [19:0]       dv_v;
  logic [40:0]       dv_prod;
  logic [15:0]       dv_q0;
  logic [19:0]       dv_r0;
  logic              dv_corr;
  logic [15:0]       dv_q;
  logic [3:0]        dv_r;
  word_t             dv_quot;
  logic              dv_last;

  always_comb begin
    dv_d    = (state == S_DDIV9) ? MAX_EXP : DEC_BASE;
    dv_m    = (state == S_DDIV9) ? RECIP_9 : RECIP_10;
    dv_v    = {rem, acc[WordW-1 -: ChunkW]};
    dv_prod = 41'(dv_v) * 41'(dv_m);
    dv_q0   = dv_prod[RecipShift +: ChunkW];
    dv_r0   = dv_v - 20'(dv_q0) * 20'(dv_d);
    // reciprocal is rounded down, so the estimate is short by at most one
    dv_corr = (dv_r0[4:0] >= 5'(dv_d));
    dv_q    = dv_corr ? dv_q0 + 16'd1 : dv_q0;
    dv_r    = dv_corr ? 4'(dv_r0[4:0] - 5'(dv_d)) : dv_r0[3:0];
    dv_quot = {acc[WordW-ChunkW-1:0], dv_q};
    dv_last = (div_cnt == 2'(NChunks - 1));
  end

  // Shared times-ten adder
  word_t mt_b;
  word_t mt_out;

  always_comb begin
    unique case (state)
      S_DFORM: mt_b = word_t'(digit);
      S_CPACK: mt_b = word_t'(exp_cnt) + word_t'(1);
      default: mt_b = '0;
    endcase
    mt_out = (acc << 3) + (acc << 1) + mt_b;
  end

  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_FIN) && (!out_valid || !out_stall);

  always_comb begin
    state_next   = state;
    acc_next     = acc;
    exp_cnt_next = exp_cnt;
    digit_next   = digit;
    rem_next     = rem;
    div_cnt_next = div_cnt;
    pack_hi_next = pack_hi;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          rem_next     = '0;
          div_cnt_next = '0;
          exp_cnt_next = '0;
          pack_hi_next = 1'b0;
          if (value_in == '0) begin
            acc_next   = '0;
            state_next = S_FIN;
          end else if (!kind) begin
            acc_next   = value_in;
            state_next = S_CDIV;
          end else begin
            acc_next   = value_in - word_t'(1);
            state_next = S_DDIV10;
          end
        end
      end
      S_CDIV: begin
        acc_next     = dv_quot;
        rem_next     = dv_r;
        div_cnt_next = div_cnt + 2'd1;
        if (dv_last) begin
          rem_next = '0;
          if (dv_r == '0) begin
            exp_cnt_next = exp_cnt + 4'd1;
            if (exp_cnt == MAX_EXP - 4'd1) begin
              // nine zeros stripped: code is 1 + (n-1)*10 + 9, i.e. n*10
              exp_cnt_next = 4'd1;
              digit_next   = MAX_EXP;
              state_next   = S_DMUL;
            end
          end else begin
            digit_next = dv_r;
            state_next = S_CPACK;
          end
        end
      end
      S_CPACK: begin
        if (!pack_hi) begin
          acc_next     = (acc << 3) + acc + word_t'(digit) - word_t'(1);
          pack_hi_next = 1'b1;
        end else begin
          acc_next   = mt_out;
          state_next = S_FIN;
        end
      end
      S_DDIV10: begin
        acc_next     = dv_quot;
        rem_next     = dv_r;
        div_cnt_next = div_cnt + 2'd1;
        if (dv_last) begin
          rem_next     = '0;
          exp_cnt_next = dv_r;
          if (dv_r < MAX_EXP) begin
            state_next = S_DDIV9;
          end else begin
            // top exponent: n = x + 1, then scale
            acc_next   = dv_quot + word_t'(1);
            state_next = S_DMUL;
          end
        end
      end
      S_DDIV9: begin
        acc_next     = dv_quot;
        rem_next     = dv_r;
        div_cnt_next = div_cnt + 2'd1;
        if (dv_last) begin
          rem_next   = '0;
          digit_next = dv_r + 4'd1;
          state_next = S_DFORM;
        end
      end
      S_DFORM: begin
        acc_next   = mt_out;
        state_next = (exp_cnt == '0) ? S_FIN : S_DMUL;
      end
      S_DMUL: begin
        acc_next     = mt_out;
        exp_cnt_next = exp_cnt - 4'd1;
        if (exp_cnt == 4'd1) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      rem       <= '0;
      exp_cnt   <= '0;
      pack_hi   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
      rem     <= rem_next;
      exp_cnt <= exp_cnt_next;
      pack_hi <= pack_hi_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc   <= acc_next;
    digit <= digit_next;
    if (out_load) begin
      value_out <= acc;
    end
  end

  a_exp_range: assert property (@(posedge clk) disable iff (rst)
    exp_cnt <= MAX_EXP)
    else $error("exponent count out of range");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_CDIV || state == S_DDIV10 || state == S_DDIV9) |-> (rem < dv_d))
    else $error("partial remainder not below divisor");

  a_div_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_FIN || state == S_DFORM || state == S_DMUL)
      |-> (div_cnt == '0 && rem == '0))
    else $error("divide unit left busy");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != S_IDLE))
    else $error("accepted item did not start");

  a_load_only_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled item");

endmodule

### tb/sv/amount_code_check_pkg.sv
package amount_code_check_pkg;

  import amcd_pkg::*;

  localparam logic KIND_COMPRESS = 1'b0;
  localparam logic KIND_EXPAND   = 1'b1;

  class amount_code_scoreboard;

    word_t expected_values[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Strip trailing decimal zeros into the exponent, then fold in the last digit.
    function word_t compress_amount(word_t amount);
      word_t q;
      word_t e;
      word_t d;
      if (amount == 0) return 0;
      q = amount;
      e = 0;
      while ((q % DEC_BASE) == 0 && e < MAX_EXP) begin
        q = q / DEC_BASE;
        e = e + 1;
      end
      if (e < MAX_EXP) begin
        d = q % DEC_BASE;
        q = q / DEC_BASE;
        return 1 + (q * 9 + d - 1) * DEC_BASE + e;
      end
      return 1 + (q - 1) * DEC_BASE + MAX_EXP;
    endfunction

    function word_t expand_code(word_t code);
      word_t x;
      word_t e;
      word_t d;
      word_t n;
      if (code == 0) return 0;
      x = code - 1;
      e = x % DEC_BASE;
      x = x / DEC_BASE;
      if (e < MAX_EXP) begin
        d = (x % 9) + 1;
        x = x / 9;
        n = x * DEC_BASE + d;
      end else begin
        n = x + 1;
      end
      while (e != 0) begin
        n = n * DEC_BASE;
        e = e - 1;
      end
      return n;
    endfunction

    function void note_item(logic kind, word_t value);
      if (kind == KIND_COMPRESS) expected_values.push_back(compress_amount(value));
      else expected_values.push_back(expand_code(value));
    endfunction

    function void check_result(word_t actual, longint unsigned stamp);
      word_t want;
      if (expected_values.size() == 0) begin
        $display("%0d ns: value_out expected none, actual %h", stamp, actual);
        errors++;
        return;
      end
      want = expected_values.pop_front();
      if (actual !== want) begin
        $display("%0d ns: value_out expected %h, actual %h", stamp, want, actual);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_values.size();
    endfunction

  endclass

endpackage

### tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import amcd_pkg::*;
  import amount_code_check_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = KIND_COMPRESS;
  logic [63:0] value_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] value_out;

  bit no_idle = 1'b0;

  amount_code_scoreboard sb = new();

  amount_compress_decompress_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .value_in  (value_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value_out (value_out)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic word_t ten_pow(int unsigned k);
    word_t p;
    p = 1;
    repeat (k) p = p * DEC_BASE;
    return p;
  endfunction

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(logic k, word_t v);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    value_in <= v;
    do @(posedge clk); while (in_stall);
    sb.note_item(k, v);
  endtask

  // Result side: stall a random number of cycles, then take one item.
  initial begin
    int unsigned gap;
    @(negedge rst);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_result(value_out, $time);
    end
  end

  initial begin
    word_t amount;
    logic  k;
    int unsigned pick;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_item(KIND_COMPRESS, 64'd0);
    send_item(KIND_EXPAND, 64'd0);
    send_item(KIND_COMPRESS, 64'd1);
    send_item(KIND_COMPRESS, 64'd9);
    send_item(KIND_COMPRESS, 64'd10);
    send_item(KIND_COMPRESS, 64'd100);
    send_item(KIND_COMPRESS, ten_pow(9));
    send_item(KIND_COMPRESS, ten_pow(10));
    send_item(KIND_COMPRESS, 64'd12345 * ten_pow(9));
    send_item(KIND_COMPRESS, ten_pow(19));
    send_item(KIND_COMPRESS, 64'd18 * ten_pow(17));
    send_item(KIND_COMPRESS, '1);
    send_item(KIND_COMPRESS, 64'h8000_0000_0000_0000);
    send_item(KIND_EXPAND, 64'd1);
    send_item(KIND_EXPAND, 64'd9);
    send_item(KIND_EXPAND, 64'd10);
    send_item(KIND_EXPAND, 64'd11);
    send_item(KIND_EXPAND, 64'd20);
    send_item(KIND_EXPAND, '1);
    send_item(KIND_EXPAND, 64'hFFFF_FFFF_FFFF_FFF6);
    send_item(KIND_EXPAND, sb.compress_amount('1));
    send_item(KIND_EXPAND, sb.compress_amount(64'd21 * ten_pow(6)));

    for (int i = 0; i < 1200; i++) begin
      no_idle = ((i / 150) % 4) == 3;
      k = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      // Four picks in ten give amounts that look like real ones: a short mantissa times a power of ten.
      if (pick < 4) amount = word_t'($urandom_range(1, 999999)) * ten_pow($urandom_range(0, 13));
      else if (pick < 7) amount = rand_word();
      else if (pick < 9) amount = rand_word() >> $urandom_range(0, 63);
      else amount = word_t'($urandom_range(0, 25));
      // For expand, those realistic amounts are first compressed into well-formed codes.
      if (k == KIND_EXPAND && pick < 4) amount = sb.compress_amount(amount);
      send_item(k, amount);
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
